@@ design/sdro_pkg.sv @@
// Package for the SCAN disk request scheduler.
// Holds the word types of both channels and the default sizes.
// No dependencies.
`timescale 1ns / 1ps

package sdro_pkg;

  localparam int CYL_W = 16;
  localparam int MAX_REQUESTS_DEF = 16;
  localparam int CYLINDER_BITS_DEF = 16;

  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             last;
  } req_t;

  typedef struct packed {
    logic [CYL_W-1:0] cylinder_res;
    logic             sweep_end;
    logic             overflowed;
    logic             last_res;
  } res_t;

  // One result word handed from the sequencer to the output register.
  typedef struct packed {
    logic load;
    res_t word;
  } emit_t;

endpackage

@@ design/sdro_ram.sv @@
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sdro_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/sdro_seq.sv @@
// Sequencer of the SCAN scheduler: loads requests into the store, sorts the
// store in place with streaming bubble passes, counts requests at or below
// the head and emits the service order. Depends on sdro_pkg.
`timescale 1ns / 1ps

module sdro_seq #(
  parameter int MAX_REQUESTS = sdro_pkg::MAX_REQUESTS_DEF,
  parameter int SW = sdro_pkg::CYLINDER_BITS_DEF,
  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  sdro_pkg::req_t     req,
  output logic               busy,
  input  logic [SW-1:0]      head,
  input  logic               taken,
  output sdro_pkg::emit_t    emit,
  output logic               we,
  output logic [AW-1:0]      waddr,
  output logic [SW-1:0]      wdata,
  output logic [AW-1:0]      raddr,
  input  logic [SW-1:0]      rdata
);
  import sdro_pkg::*;

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_REQUESTS);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_SORT  = 7'b0000010,
    S_FLUSH = 7'b0000100,
    S_SPLIT = 7'b0001000,
    S_ERD   = 7'b0010000,
    S_ELD   = 7'b0100000,
    S_EHOLD = 7'b1000000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] pass, pass_next;
  logic [CW-1:0] iss, iss_next;
  logic          rvalid, rvalid_next;
  logic [CW-1:0] ridx, ridx_next;
  logic [SW-1:0] carry, carry_next;
  logic [CW-1:0] split, split_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] slot_addr;
  logic          accept;

  assign busy   = (state != S_LOAD);
  assign accept = req_valid && !busy;

  // Store address of output slot k: descending below the split, the
  // turnaround at the split itself, ascending above it.
  always_comb begin
    if (k < split) begin
      slot_addr = split - 1'b1 - k;
    end else if (k > split) begin
      slot_addr = k - 1'b1;
    end else begin
      slot_addr = '0;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    ovf_next    = ovf;
    pass_next   = pass;
    iss_next    = iss;
    rvalid_next = 1'b0;
    ridx_next   = ridx;
    carry_next  = carry;
    split_next  = split;
    k_next      = k;
    we          = 1'b0;
    waddr       = count[AW-1:0];
    wdata       = req.cylinder[SW-1:0];
    raddr       = iss[AW-1:0];
    emit        = '0;

    case (state)
      S_LOAD: begin
        if (accept) begin
          if (count < MAX_C) begin
            we         = 1'b1;
            count_next = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          if (req.last) begin
            pass_next  = '0;
            iss_next   = '0;
            split_next = '0;
            k_next     = '0;
            if (count_next > CW'(1)) begin
              state_next = S_SORT;
            end else if (count_next == CW'(1)) begin
              state_next = S_SPLIT;
            end else begin
              state_next = S_ERD;
            end
          end
        end
      end

      // One bubble pass: the larger value rides along in carry while the
      // smaller one is written back one place behind the read pointer.
      S_SORT: begin
        if (iss < count) begin
          iss_next    = iss + 1'b1;
          rvalid_next = 1'b1;
          ridx_next   = iss;
        end
        if (rvalid) begin
          if (ridx == '0) begin
            carry_next = rdata;
          end else begin
            we     = 1'b1;
            waddr  = AW'(ridx - 1'b1);
            wdata  = (rdata < carry) ? rdata : carry;
            carry_next = (rdata < carry) ? carry : rdata;
          end
          if (ridx == count - 1'b1) begin
            state_next = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        we        = 1'b1;
        waddr     = AW'(count - 1'b1);
        wdata     = carry;
        pass_next = pass + 1'b1;
        iss_next  = '0;
        if (pass_next >= count - 1'b1) begin
          state_next = S_SPLIT;
        end else begin
          state_next = S_SORT;
        end
      end

      S_SPLIT: begin
        if (iss < count) begin
          iss_next    = iss + 1'b1;
          rvalid_next = 1'b1;
          ridx_next   = iss;
        end
        if (rvalid) begin
          if (rdata <= head) begin
            split_next = split + 1'b1;
          end
          if (ridx == count - 1'b1) begin
            state_next = S_ERD;
          end
        end
      end

      S_ERD: begin
        raddr      = slot_addr[AW-1:0];
        state_next = S_ELD;
      end

      S_ELD: begin
        emit.load            = 1'b1;
        emit.word.sweep_end  = (k == split);
        emit.word.cylinder_res = (k == split) ? '0 : CYL_W'(rdata);
        emit.word.overflowed = ovf;
        emit.word.last_res   = (k == count);
        state_next           = S_EHOLD;
      end

      S_EHOLD: begin
        if (taken) begin
          if (k == count) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = S_LOAD;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_ERD;
          end
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      count  <= '0;
      ovf    <= 1'b0;
      rvalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      ovf    <= ovf_next;
      rvalid <= rvalid_next;
    end
    pass  <= pass_next;
    iss   <= iss_next;
    ridx  <= ridx_next;
    carry <= carry_next;
    split <= split_next;
    k     <= k_next;
  end

endmodule

@@ design/scan_disk_request_order.sv @@
// SCAN disk scheduler, sweeping toward cylinder 0 first. Requests are taken
// one word per cycle into the request store while req_stall is low; the word
// flagged last closes the batch. The store (one RAM, one read and one write
// port) is then sorted in place by n-1 bubble passes, scanned once more to
// count requests at or below head_position, and the n+1 results are read out
// one per RAM access, the next only after the last one is taken. Requests
// beyond MAX_REQUESTS are dropped and every result of that batch carries
// overflowed. Depends on sdro_pkg, sdro_ram and sdro_seq.
`timescale 1ns / 1ps

module scan_disk_request_order #(
  parameter int MAX_REQUESTS  = sdro_pkg::MAX_REQUESTS_DEF,
  parameter int CYLINDER_BITS = sdro_pkg::CYLINDER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  sdro_pkg::req_t              req,
  output logic                        res_valid,
  input  logic                        res_stall,
  output sdro_pkg::res_t              res,
  input  logic                        cfg_we,
  input  logic [sdro_pkg::CYL_W-1:0]  cfg_wdata
);
  import sdro_pkg::*;

  localparam int SW = (CYLINDER_BITS < CYL_W) ? CYLINDER_BITS : CYL_W;
  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic [SW-1:0] head;
  emit_t         emit;
  logic          taken;
  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [SW-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (cfg_we) begin
      head <= cfg_wdata[SW-1:0];
    end
  end

  assign taken = res_valid && !res_stall;

  // Output register: holds one result word until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit.load) begin
      res_valid <= 1'b1;
    end else if (taken) begin
      res_valid <= 1'b0;
    end
    if (emit.load) begin
      res <= emit.word;
    end
  end

  sdro_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_REQUESTS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  sdro_seq #(
    .MAX_REQUESTS(MAX_REQUESTS),
    .SW          (SW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req      (req),
    .busy     (req_stall),
    .head     (head),
    .taken    (taken),
    .emit     (emit),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata)
  );

`ifndef SYNTHESIS
  // No request word is taken while a result word is still pending.
  a_no_req_while_res: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> req_stall)
    else $error("request accepted while a result word is pending");

  // The sequencer never overwrites a result word that was not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit.load |-> !res_valid)
    else $error("result register overwritten before it was taken");

  // After the final word of an order is taken, the block returns to loading.
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    (taken && res.last_res) |=> (!res_valid && !req_stall))
    else $error("block did not return to loading after the final word");

  // The turnaround word always reports cylinder 0.
  a_turn_zero: assert property (@(posedge clk) disable iff (rst)
    (emit.load && emit.word.sweep_end) |-> (emit.word.cylinder_res == '0))
    else $error("turnaround word with a nonzero cylinder");
`endif

endmodule
